// File: hdl/srmmt_pkg.sv
// Package for the scan report max-merge table: sizes, codes and the microcode program.
package srmmt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FIELD_W     = 16;
    localparam int ENTRY_W     = 3 * FIELD_W;

    typedef enum logic [1:0] {
        REQ_DETECT   = 2'd0,
        REQ_END_SCAN = 2'd1,
        REQ_CLEAR    = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_FETCH,
        ST_DISPATCH,
        ST_IS_END,
        ST_IS_DETECT,
        ST_SEARCH,
        ST_COMPARE,
        ST_UPDATE,
        ST_APPEND,
        ST_FLUSH_RD,
        ST_FLUSH_OUT,
        ST_FLUSH_NEXT,
        ST_FLUSH_DONE
    } step_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_FIRE,
        C_SKIP,
        C_IS_END,
        C_DETECT_ON,
        C_BEFORE_CNT,
        C_MISS,
        C_GREATER,
        C_ROOM,
        C_OUT_FREE
    } cond_t;

    // actions fire only when the word's condition is true
    typedef struct packed {
        logic  in_ready;
        cond_t cond;
        step_t t_true;
        step_t t_false;
        logic  latch;
        logic  idx_clr;
        logic  idx_inc;
        logic  ram_rd;
        logic  ram_wr;
        logic  cnt_inc;
        logic  cnt_clr;
        logic  out_load;
    } ucode_t;

    function automatic ucode_t uw(input logic rdy, input cond_t c, input step_t tt,
                                  input step_t tf, input logic [7:0] act);
        ucode_t w;
        w.in_ready = rdy;
        w.cond     = c;
        w.t_true   = tt;
        w.t_false  = tf;
        {w.latch, w.idx_clr, w.idx_inc, w.ram_rd,
         w.ram_wr, w.cnt_inc, w.cnt_clr, w.out_load} = act;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        case (s)
            ST_FETCH:      w = uw(1'b1, C_IN_FIRE,    ST_DISPATCH,   ST_FETCH,      8'b1100_0000);
            ST_DISPATCH:   w = uw(1'b0, C_SKIP,       ST_FETCH,      ST_IS_END,     8'b0000_0010);
            ST_IS_END:     w = uw(1'b0, C_IS_END,     ST_FLUSH_RD,   ST_IS_DETECT,  8'b0000_0000);
            ST_IS_DETECT:  w = uw(1'b0, C_DETECT_ON,  ST_SEARCH,     ST_FETCH,      8'b0000_0000);
            ST_SEARCH:     w = uw(1'b0, C_BEFORE_CNT, ST_COMPARE,    ST_APPEND,     8'b0001_0000);
            ST_COMPARE:    w = uw(1'b0, C_MISS,       ST_SEARCH,     ST_UPDATE,     8'b0010_0000);
            ST_UPDATE:     w = uw(1'b0, C_GREATER,    ST_FETCH,      ST_FETCH,      8'b0000_1000);
            ST_APPEND:     w = uw(1'b0, C_ROOM,       ST_FETCH,      ST_FETCH,      8'b0000_1100);
            ST_FLUSH_RD:   w = uw(1'b0, C_ALWAYS,     ST_FLUSH_OUT,  ST_FLUSH_OUT,  8'b0001_0000);
            ST_FLUSH_OUT:  w = uw(1'b0, C_OUT_FREE,   ST_FLUSH_NEXT, ST_FLUSH_OUT,  8'b0010_0001);
            ST_FLUSH_NEXT: w = uw(1'b0, C_BEFORE_CNT, ST_FLUSH_RD,   ST_FLUSH_DONE, 8'b0000_0000);
            ST_FLUSH_DONE: w = uw(1'b0, C_ALWAYS,     ST_FETCH,      ST_FETCH,      8'b0000_0010);
            default:       w = uw(1'b0, C_ALWAYS,     ST_FETCH,      ST_FETCH,      8'b0000_0000);
        endcase
        return w;
    endfunction

endpackage

// File: hdl/srmmt_req_if.sv
// Request channel interface: detection, end-of-scan and clear items.
interface srmmt_req_if;
    import srmmt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [FIELD_W-1:0]         target_id;
    logic [FIELD_W-1:0]         emission_tag;
    logic signed [FIELD_W-1:0]  snr_db;

    modport source (output valid, output req_type, output target_id,
                    output emission_tag, output snr_db, input ready);
    modport sink   (input valid, input req_type, input target_id,
                    input emission_tag, input snr_db, output ready);
endinterface

// File: hdl/srmmt_rpt_if.sv
// Report channel interface: one item per emitted table entry.
interface srmmt_rpt_if;
    import srmmt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [FIELD_W-1:0]         out_target_id;
    logic [FIELD_W-1:0]         out_emission_tag;
    logic signed [FIELD_W-1:0]  out_snr_db;
    logic                       last_report;

    modport source (output valid, output out_target_id, output out_emission_tag,
                    output out_snr_db, output last_report, input ready);
    modport sink   (input valid, input out_target_id, input out_emission_tag,
                    input out_snr_db, input last_report, output ready);
endinterface

// File: hdl/scan_report_max_merge_table_top.sv
// Top level of the scan report max-merge table: microcoded sequencer over an entry RAM.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type, target_id, emission_tag, snr_db
//  rpt      out  valid/ready    out_target_id, out_emission_tag, out_snr_db, last_report
//  cfg      in   cfg_we         cfg_wdata (track_manager_present)
//
// One item at a time; ready is high only in the fetch step.
// Detection: the stored entries are read through the registered RAM port and compared
// one at a time; a match is updated if the new SNR is greater, a miss is appended if
// there is room. End of scan emits the entries in order; clear and dropped items
// return to fetch. A stalled rpt holds the flush step.
// Reset clears the step counter, entry count and output valid; register resets to 1.
module scan_report_max_merge_table_top (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    srmmt_req_if.sink   req,
    srmmt_rpt_if.source rpt
);
    import srmmt_pkg::*;

    step_t                      step_reg, step_next;
    logic                       tmp_reg;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [1:0]                 item_req_reg;
    logic [FIELD_W-1:0]         item_tgt_reg;
    logic [FIELD_W-1:0]         item_tag_reg;
    logic signed [FIELD_W-1:0]  item_snr_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]         out_tgt_reg;
    logic [FIELD_W-1:0]         out_tag_reg;
    logic signed [FIELD_W-1:0]  out_snr_reg;
    logic                       out_last_reg;

    ucode_t                     uc;
    logic                       cond_ok;
    logic                       ram_we, ram_re;
    logic [ENTRY_W-1:0]         ram_rdata;
    logic [FIELD_W-1:0]         rd_tgt;
    logic [FIELD_W-1:0]         rd_tag;
    logic signed [FIELD_W-1:0]  rd_snr;
    logic                       out_free;
    logic                       is_end;
    logic                       is_last;

    assign uc       = ucode_rom(step_reg);
    assign rd_tgt   = ram_rdata[ENTRY_W-1 -: FIELD_W];
    assign rd_tag   = ram_rdata[2*FIELD_W-1 -: FIELD_W];
    assign rd_snr   = signed'(ram_rdata[FIELD_W-1:0]);
    assign out_free = !out_valid_reg || rpt.ready;
    assign is_end   = (item_req_reg == REQ_END_SCAN);
    assign is_last  = ((idx_reg + CNT_W'(1)) == cnt_reg);

    always_comb
    begin
        case (uc.cond)
            C_ALWAYS:     cond_ok = 1'b1;
            C_IN_FIRE:    cond_ok = req.valid;
            C_SKIP:       cond_ok = (item_req_reg == REQ_CLEAR)
                                    || (is_end && (!tmp_reg || cnt_reg == '0));
            C_IS_END:     cond_ok = is_end;
            C_DETECT_ON:  cond_ok = (item_req_reg == REQ_DETECT) && tmp_reg;
            C_BEFORE_CNT: cond_ok = (idx_reg != cnt_reg);
            C_MISS:       cond_ok = (rd_tgt != item_tgt_reg);
            C_GREATER:    cond_ok = (item_snr_reg > rd_snr);
            C_ROOM:       cond_ok = (cnt_reg != CNT_W'(TABLE_DEPTH));
            C_OUT_FREE:   cond_ok = out_free;
            default:      cond_ok = 1'b0;
        endcase
    end

    assign ram_we = uc.ram_wr && cond_ok;
    assign ram_re = uc.ram_rd && cond_ok;

    always_comb
    begin
        step_next      = cond_ok ? uc.t_true : uc.t_false;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (rpt.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cond_ok)
        begin
            if (uc.idx_clr)
            begin
                idx_next = '0;
            end
            if (uc.idx_inc)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            if (uc.cnt_inc)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (uc.cnt_clr)
            begin
                cnt_next = '0;
            end
            if (uc.out_load)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_FETCH;
            tmp_reg       <= 1'b1;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tmp_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (uc.latch && cond_ok)
        begin
            item_req_reg <= req.req_type;
            item_tgt_reg <= req.target_id;
            item_tag_reg <= req.emission_tag;
            item_snr_reg <= req.snr_db;
        end
        if (uc.out_load && cond_ok)
        begin
            out_tgt_reg  <= rd_tgt;
            out_tag_reg  <= rd_tag;
            out_snr_reg  <= rd_snr;
            out_last_reg <= is_last;
        end
    end

    srmmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (idx_reg[IDX_W-1:0]),
        .wdata ({item_tgt_reg, item_tag_reg, item_snr_reg}),
        .rdata (ram_rdata)
    );

    assign req.ready            = uc.in_ready;
    assign rpt.valid            = out_valid_reg;
    assign rpt.out_target_id    = out_tgt_reg;
    assign rpt.out_emission_tag = out_tag_reg;
    assign rpt.out_snr_db       = out_snr_reg;
    assign rpt.last_report      = out_last_reg;
endmodule

// File: hdl/srmmt_ram.sv
// Generic single-port RAM with registered read.
module srmmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: bench/srmmt_checker.sv
// Checker for the scan report max-merge table: tracks the per-scan table and compares reports.
module srmmt_checker
    import srmmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    srmmt_req_if req,
    srmmt_rpt_if rpt,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [FIELD_W-1:0]        target;
        logic [FIELD_W-1:0]        tag;
        logic signed [FIELD_W-1:0] snr;
        logic                      last;
    } report_t;

    logic                      mgr_on = 1'b1;
    int                        n_entries = 0;
    logic [FIELD_W-1:0]        tbl_target [TABLE_DEPTH];
    logic [FIELD_W-1:0]        tbl_tag    [TABLE_DEPTH];
    logic signed [FIELD_W-1:0] tbl_snr    [TABLE_DEPTH];
    report_t                   report_q [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic merge_detection(input logic [FIELD_W-1:0] tgt,
                                   input logic [FIELD_W-1:0] tag,
                                   input logic signed [FIELD_W-1:0] snr);
        int hit;
        hit = -1;
        if (!mgr_on)
            return;
        for (int i = 0; i < n_entries; i++)
            if (hit < 0 && tbl_target[i] == tgt)
                hit = i;
        if (hit >= 0)
        begin
            if (snr > tbl_snr[hit])
            begin
                tbl_tag[hit] = tag;
                tbl_snr[hit] = snr;
            end
        end
        else if (n_entries < TABLE_DEPTH)
        begin
            tbl_target[n_entries] = tgt;
            tbl_tag[n_entries]    = tag;
            tbl_snr[n_entries]    = snr;
            n_entries++;
        end
    endtask

    task automatic flush_scan();
        report_t r;
        if (mgr_on)
            for (int i = 0; i < n_entries; i++)
            begin
                r.target = tbl_target[i];
                r.tag    = tbl_tag[i];
                r.snr    = tbl_snr[i];
                r.last   = (i == n_entries - 1);
                report_q.push_back(r);
            end
        n_entries = 0;
    endtask

    task automatic check_report();
        report_t want;
        if (report_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: unexpected report target %h tag %h snr %h last %b", $time,
                         rpt.out_target_id, rpt.out_emission_tag, rpt.out_snr_db,
                         rpt.last_report);
            return;
        end
        want = report_q.pop_front();
        if (rpt.out_target_id !== want.target || rpt.out_emission_tag !== want.tag ||
            rpt.out_snr_db !== want.snr || rpt.last_report !== want.last)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: report mismatch exp %h/%h/%h/%b got %h/%h/%h/%b", $time,
                         want.target, want.tag, want.snr, want.last,
                         rpt.out_target_id, rpt.out_emission_tag, rpt.out_snr_db,
                         rpt.last_report);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mgr_on    = 1'b1;
            n_entries = 0;
            report_q.delete();
        end
        else
        begin
            // reports from a finished flush are checked before a new item lands
            if (rpt.valid && rpt.ready)
                check_report();
            if (cfg_we)
                mgr_on = cfg_wdata;
            if (req.valid && req.ready)
            begin
                case (req.req_type)
                    REQ_DETECT:   merge_detection(req.target_id, req.emission_tag, req.snr_db);
                    REQ_END_SCAN: flush_scan();
                    REQ_CLEAR:    n_entries = 0;
                    default:      ;
                endcase
            end
        end
        pending = report_q.size();
    end

endmodule

// File: bench/tb.sv
// Testbench top for the scan report max-merge table: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srmmt_pkg::*;

    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_count;
    int   pending;
    int   stall_pct = 0;
    int   burst_left = 0;

    srmmt_req_if req_bus ();
    srmmt_rpt_if rpt_bus ();

    scan_report_max_merge_table_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus),
        .rpt       (rpt_bus)
    );

    srmmt_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req_bus),
        .rpt        (rpt_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        rpt_bus.ready <= ($urandom_range(0, 99) >= stall_pct);

    initial
    begin
        #5ms;
        $display("scan_report_max_merge_table_top test failed");
        $finish;
    end

    function automatic logic [FIELD_W-1:0] rand_field();
        return FIELD_W'($urandom);
    endfunction

    // burst/gap pacing after each accepted item
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic send_req(input req_t kind, input logic [FIELD_W-1:0] tgt,
                            input logic [FIELD_W-1:0] tag,
                            input logic signed [FIELD_W-1:0] snr);
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= kind;
        req_bus.target_id    <= tgt;
        req_bus.emission_tag <= tag;
        req_bus.snr_db       <= snr;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        pace();
    endtask

    // hold off until every report is in and the sequencer is back in fetch
    task automatic settle_table();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mgr_present(input logic on);
        settle_table();
        cfg_wdata <= on;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [FIELD_W-1:0] pick_snr();
        if ($urandom_range(0, 1))
            return FIELD_W'($urandom);
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0100;
        endcase
    endfunction

    // scans of detections over a target pool, closed by end of scan or clear
    task automatic run_scans(input int n_items);
        logic [FIELD_W-1:0] pool [20];
        int done;
        int pool_sz;
        int dets;
        done = 0;
        while (done < n_items)
        begin
            pool_sz = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 20)
                                                  : $urandom_range(1, 12);
            foreach (pool[k])
                pool[k] = rand_field();
            dets = $urandom_range(pool_sz, 2 * pool_sz);
            for (int d = 0; d < dets; d++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_req(REQ_UNUSED, rand_field(), rand_field(), rand_field());
                if ($urandom_range(0, 40) == 0)
                begin
                    send_req(REQ_CLEAR, rand_field(), rand_field(), rand_field());
                    done++;
                end
                send_req(REQ_DETECT, pool[$urandom_range(0, pool_sz - 1)], rand_field(),
                         pick_snr());
            end
            if ($urandom_range(0, 9) == 0)
                send_req(REQ_CLEAR, rand_field(), rand_field(), rand_field());
            else
                send_req(REQ_END_SCAN, rand_field(), rand_field(), rand_field());
            done += dets + 1;
            if ($urandom_range(0, 5) == 0)
                settle_table();
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.req_type     = REQ_DETECT;
        req_bus.target_id    = '0;
        req_bus.emission_tag = '0;
        req_bus.snr_db       = '0;
        rpt_bus.ready        = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty flush, equal/greater/lower merges, unused code, clear
        send_req(REQ_END_SCAN, rand_field(), rand_field(), rand_field());
        send_req(REQ_DETECT, 16'h0000, 16'h0000, 16'h8000);
        send_req(REQ_DETECT, 16'h0000, 16'hFFFF, 16'h8000);
        send_req(REQ_DETECT, 16'h0000, 16'h1234, 16'h7FFF);
        send_req(REQ_DETECT, 16'h0000, 16'h0001, 16'h0100);
        send_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_req(REQ_CLEAR, rand_field(), rand_field(), rand_field());
        // fill the table, then overflow and merge while full
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_req(REQ_DETECT, FIELD_W'(i * 16'h1111), FIELD_W'(~(i * 16'h1111)),
                     FIELD_W'(i * 4369 - 32768));
        send_req(REQ_DETECT, 16'hABCD, 16'h5A5A, 16'h7FFF);
        send_req(REQ_DETECT, 16'h5555, 16'hBEEF, 16'h7FFF);
        send_req(REQ_END_SCAN, rand_field(), rand_field(), rand_field());

        set_mgr_present(1'b1);
        stall_pct = 30;
        run_scans(12);
        set_mgr_present(1'b0);
        run_scans(18);
        set_mgr_present(1'b1);
        stall_pct = 0;
        run_scans(36);
        stall_pct = 50;
        run_scans(30);
        set_mgr_present(1'b0);
        stall_pct = 10;
        run_scans(12);
        set_mgr_present(1'b1);
        stall_pct = 80;
        run_scans(32);

        settle_table();
        if (fail_count == 0 && pending == 0)
            $display("scan_report_max_merge_table_top test passed");
        else
            $display("scan_report_max_merge_table_top test failed");
        $finish;
    end

endmodule
